FILE: rtl/core/mhpq_pkg.sv
// shared constants, types and helpers for the min-heap priority queue
// no dependencies; used by mhpq_front, mhpq_back and min_heap_priority_queue
`default_nettype none

package mhpq_pkg;

  localparam int CAPACITY = 256;
  localparam int KEY_W    = 32;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // request opcodes as they arrive on the port
  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_EXTRACT = 2'd1;
  localparam logic [1:0] OP_PEEK    = 2'd2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_INSERT,
    CMD_EXTRACT,
    CMD_PEEK,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [KEY_W-1:0]   key;
  } cmd_t;

  // signed compare of two stored keys
  function automatic logic key_less(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

  // heap position (1-based) to store address
  function automatic logic [ADDR_W-1:0] pos2addr(input logic [CNT_W-1:0] p);
    logic [CNT_W-1:0] q;
    q = p - CNT_W'(1);
    return q[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/mhpq_front.sv
// request side: accepts requests, decodes the opcode and holds them in a
// two-entry command queue for the heap engine; depends on mhpq_pkg
`default_nettype none

module mhpq_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_push,
  input  wire logic [1:0]                 in_opcode,
  input  wire logic [mhpq_pkg::KEY_W-1:0] in_key,
  output logic                            in_full,
  output logic                            cmd_valid,
  output mhpq_pkg::cmd_t                  cmd,
  input  wire logic                       cmd_take
);

  mhpq_pkg::cmd_t    ent_r [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        fill_r;
  logic              push_ok;
  logic              take_ok;
  mhpq_pkg::cmd_t    dec;

  assign in_full   = (fill_r == 2'd2);
  assign cmd_valid = (fill_r != 2'd0);
  assign cmd       = ent_r[rd_ptr_r];
  assign push_ok   = in_push && !in_full;
  assign take_ok   = cmd_take && cmd_valid;

  always_comb begin
    dec.key = in_key;
    unique case (in_opcode)
      mhpq_pkg::OP_INSERT:  dec.kind = mhpq_pkg::CMD_INSERT;
      mhpq_pkg::OP_EXTRACT: dec.kind = mhpq_pkg::CMD_EXTRACT;
      mhpq_pkg::OP_PEEK:    dec.kind = mhpq_pkg::CMD_PEEK;
      default:              dec.kind = mhpq_pkg::CMD_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      ent_r[wr_ptr_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (take_ok) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push_ok, take_ok})
        2'b10:   fill_r <= fill_r + 2'd1;
        2'b01:   fill_r <= fill_r - 2'd1;
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/mhpq_back.sv
// heap engine: key store with two read ports and one write port, sift
// sequencer and one-entry result register; depends on mhpq_pkg
`default_nettype none

module mhpq_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cmd_valid,
  input  wire mhpq_pkg::cmd_t              cmd,
  output logic                             cmd_take,
  output logic                             out_empty,
  input  wire logic                        out_pop,
  output logic [mhpq_pkg::KEY_W-1:0]       out_min_key,
  output logic [1:0]                       out_status,
  output logic [mhpq_pkg::CNT_W-1:0]       out_entries
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_UP_CMP = 6'b000010,
    S_EX_LD  = 6'b000100,
    S_DN_CMP = 6'b001000,
    S_PK     = 6'b010000,
    S_PUT    = 6'b100000
  } state_t;

  logic [mhpq_pkg::KEY_W-1:0]  mem [mhpq_pkg::CAPACITY];
  logic [mhpq_pkg::KEY_W-1:0]  rd_a_q;
  logic [mhpq_pkg::KEY_W-1:0]  rd_b_q;
  logic [mhpq_pkg::ADDR_W-1:0] rd_a_addr;
  logic [mhpq_pkg::ADDR_W-1:0] rd_b_addr;
  logic                        we;
  logic [mhpq_pkg::ADDR_W-1:0] wa;
  logic [mhpq_pkg::KEY_W-1:0]  wd;

  state_t                      state_r, state_nxt;
  logic [mhpq_pkg::CNT_W-1:0]  pos_r, pos_nxt;
  logic [mhpq_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [mhpq_pkg::KEY_W-1:0]  cur_r, cur_nxt;
  logic [mhpq_pkg::KEY_W-1:0]  min_r, min_nxt;

  logic                        res_valid_r;
  logic [mhpq_pkg::KEY_W-1:0]  res_min_r;
  mhpq_pkg::status_t           res_status_r;
  logic [mhpq_pkg::CNT_W-1:0]  res_entries_r;

  logic                        done;
  logic [mhpq_pkg::KEY_W-1:0]  done_min;
  mhpq_pkg::status_t           done_status;

  // sift-down and insert helpers
  logic [mhpq_pkg::CNT_W:0]    left_w;
  logic                        only_left;
  logic                        pick_right;
  logic [mhpq_pkg::KEY_W-1:0]  pick_data;
  logic [mhpq_pkg::CNT_W-1:0]  pick_pos;
  logic [mhpq_pkg::CNT_W:0]    next_left_w;
  logic [mhpq_pkg::CNT_W:0]    next_left_m1;
  logic [mhpq_pkg::CNT_W-1:0]  ins_pos;

  assign out_empty   = !res_valid_r;
  assign out_min_key = res_min_r;
  assign out_status  = res_status_r;
  assign out_entries = res_entries_r;

  assign left_w       = {pos_r, 1'b0};
  assign only_left    = (left_w == {1'b0, count_r});
  assign pick_right   = !only_left && !mhpq_pkg::key_less(rd_a_q, rd_b_q);
  assign pick_data    = pick_right ? rd_b_q : rd_a_q;
  assign pick_pos     = pick_right ? (left_w[mhpq_pkg::CNT_W-1:0] + mhpq_pkg::CNT_W'(1))
                                   : left_w[mhpq_pkg::CNT_W-1:0];
  assign next_left_w  = {pick_pos, 1'b0};
  assign next_left_m1 = next_left_w - (mhpq_pkg::CNT_W+1)'(1);
  assign ins_pos      = count_r + mhpq_pkg::CNT_W'(1);

  // key store: registered reads on both ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a_q <= mem[rd_a_addr];
    rd_b_q <= mem[rd_b_addr];
  end

  always_comb begin
    state_nxt   = state_r;
    pos_nxt     = pos_r;
    count_nxt   = count_r;
    cur_nxt     = cur_r;
    min_nxt     = min_r;
    rd_a_addr   = '0;
    rd_b_addr   = '0;
    we          = 1'b0;
    wa          = mhpq_pkg::pos2addr(pos_r);
    wd          = cur_r;
    cmd_take    = 1'b0;
    done        = 1'b0;
    done_min    = '0;
    done_status = mhpq_pkg::ST_OK;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && (!res_valid_r || out_pop)) begin
          cmd_take = 1'b1;
          unique case (cmd.kind)
            mhpq_pkg::CMD_INSERT: begin
              if (count_r == mhpq_pkg::CNT_W'(mhpq_pkg::CAPACITY)) begin
                done        = 1'b1;
                done_status = mhpq_pkg::ST_FULL;
              end else begin
                count_nxt = ins_pos;
                pos_nxt   = ins_pos;
                cur_nxt   = cmd.key;
                min_nxt   = '0;
                if (count_r == '0) begin
                  we   = 1'b1;
                  wa   = '0;
                  wd   = cmd.key;
                  done = 1'b1;
                end else begin
                  rd_a_addr = mhpq_pkg::pos2addr(ins_pos >> 1);
                  state_nxt = S_UP_CMP;
                end
              end
            end
            mhpq_pkg::CMD_EXTRACT: begin
              if (count_r == '0) begin
                done        = 1'b1;
                done_status = mhpq_pkg::ST_EMPTY;
              end else begin
                rd_a_addr = '0;
                rd_b_addr = mhpq_pkg::pos2addr(count_r);
                count_nxt = count_r - mhpq_pkg::CNT_W'(1);
                state_nxt = S_EX_LD;
              end
            end
            mhpq_pkg::CMD_PEEK: begin
              if (count_r == '0) begin
                done        = 1'b1;
                done_status = mhpq_pkg::ST_EMPTY;
              end else begin
                rd_a_addr = '0;
                state_nxt = S_PK;
              end
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end

      // hole moves up one level per cycle, parent read issued alongside
      S_UP_CMP: begin
        if (mhpq_pkg::key_less(cur_r, rd_a_q)) begin
          we      = 1'b1;
          wd      = rd_a_q;
          pos_nxt = pos_r >> 1;
          if ((pos_r >> 1) > mhpq_pkg::CNT_W'(1)) begin
            rd_a_addr = mhpq_pkg::pos2addr(pos_r >> 2);
          end else begin
            state_nxt = S_PUT;
          end
        end else begin
          we       = 1'b1;
          done     = 1'b1;
          done_min = min_r;
        end
      end

      // root and last entry arrive; last entry becomes the sifting key
      S_EX_LD: begin
        min_nxt = rd_a_q;
        cur_nxt = rd_b_q;
        pos_nxt = mhpq_pkg::CNT_W'(1);
        if (count_r >= mhpq_pkg::CNT_W'(2)) begin
          rd_a_addr = mhpq_pkg::ADDR_W'(1);
          rd_b_addr = mhpq_pkg::ADDR_W'(2);
          state_nxt = S_DN_CMP;
        end else begin
          we       = 1'b1;
          wa       = '0;
          wd       = rd_b_q;
          done     = 1'b1;
          done_min = rd_a_q;
        end
      end

      S_DN_CMP: begin
        if (mhpq_pkg::key_less(pick_data, cur_r)) begin
          we      = 1'b1;
          wd      = pick_data;
          pos_nxt = pick_pos;
          if (next_left_w <= {1'b0, count_r}) begin
            rd_a_addr = next_left_m1[mhpq_pkg::ADDR_W-1:0];
            rd_b_addr = next_left_w[mhpq_pkg::ADDR_W-1:0];
          end else begin
            state_nxt = S_PUT;
          end
        end else begin
          we       = 1'b1;
          done     = 1'b1;
          done_min = min_r;
        end
      end

      S_PK: begin
        done     = 1'b1;
        done_min = rd_a_q;
      end

      S_PUT: begin
        we       = 1'b1;
        done     = 1'b1;
        done_min = min_r;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (done) begin
      state_nxt = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    cur_r <= cur_nxt;
    min_r <= min_nxt;
    if (done) begin
      res_min_r     <= done_min;
      res_status_r  <= done_status;
      res_entries_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (done) begin
        res_valid_r <= 1'b1;
      end else if (out_pop) begin
        res_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/min_heap_priority_queue.sv
// top level of the binary min-heap priority queue: request queue in front,
// heap engine with result register behind; depends on mhpq_pkg, mhpq_front, mhpq_back
//
//   channel   direction  handshake        payload
//   in_       request    in_push/in_full  in_opcode, in_key
//   out_      result     out_pop/empty    out_min_key, out_status, out_entries
//
// one result per request, in request order; the store does one heap level per
// cycle (two registered reads, one write); a rejected or unused request is
// answered from the idle state without a read of the store
// reset clears the count and both queues; the key store needs no clearing
// requests keep entering the two-entry queue while a result waits to be popped
// the engine starts the next request once the result register is free
`default_nettype none

module min_heap_priority_queue (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_push,
  output logic                            in_full,
  input  wire logic [1:0]                 in_opcode,
  input  wire logic [mhpq_pkg::KEY_W-1:0] in_key,
  output logic                            out_empty,
  input  wire logic                       out_pop,
  output logic [mhpq_pkg::KEY_W-1:0]      out_min_key,
  output logic [1:0]                      out_status,
  output logic [mhpq_pkg::CNT_W-1:0]      out_entries
);

  logic            cmd_valid;
  mhpq_pkg::cmd_t  cmd;
  logic            cmd_take;

  mhpq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_opcode (in_opcode),
    .in_key    (in_key),
    .in_full   (in_full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  mhpq_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_take    (cmd_take),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_min_key (out_min_key),
    .out_status  (out_status),
    .out_entries (out_entries)
  );

endmodule

`default_nettype wire
